// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define CSPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CSPS_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/csps_pkg.sv =====
// Types and constants of the cardinal spline path stepper.
// No dependencies; used by the interfaces, the lanes, the basis unit and the top level.
package csps_pkg;

  localparam int STEP_W     = 22;
  localparam int SCALE_W    = 24;
  localparam int SEG_W      = 6;
  localparam int IDX_IN_W   = 6;
  localparam int COORD_W    = 32;
  localparam int T_W        = 16;
  localparam int H_W        = 18;
  localparam int M_W        = 41;
  localparam int PROD_W     = 65;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_LANES  = 4;

  localparam logic [STEP_W-1:0]         STEP_RESET  = 22'd655;
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 24'sd32768;
  localparam logic [SEG_W-1:0]          SEGS_RESET  = 6'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_M1,
    OP_M2,
    OP_H00P1,
    OP_H01P2,
    OP_H10M1,
    OP_H11M2
  } lane_op_e;

  typedef struct packed {
    logic [3:0] ld_p;
    lane_op_e   op;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [H_W-1:0] h00;
    logic signed [H_W-1:0] h10;
    logic signed [H_W-1:0] h01;
    logic signed [H_W-1:0] h11;
  } basis_t;

endpackage

// ===== rtl/core/csps_if.sv =====
// Valid/ready channel interfaces of the spline path stepper: request, result, configuration.
// Depends on csps_pkg for field widths.
interface csps_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic [csps_pkg::IDX_IN_W-1:0]          point_index;
  logic signed [csps_pkg::COORD_W-1:0]    coord_x;
  logic signed [csps_pkg::COORD_W-1:0]    coord_y;
  logic signed [csps_pkg::COORD_W-1:0]    coord_z;
  logic signed [csps_pkg::COORD_W-1:0]    coord_w;

  modport source (output valid, req_type, point_index, coord_x, coord_y, coord_z, coord_w,
                  input ready);
  modport sink (input valid, req_type, point_index, coord_x, coord_y, coord_z, coord_w,
                output ready);
endinterface

interface csps_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [csps_pkg::COORD_W-1:0] out_x;
  logic signed [csps_pkg::COORD_W-1:0] out_y;
  logic signed [csps_pkg::COORD_W-1:0] out_z;
  logic signed [csps_pkg::COORD_W-1:0] out_w;
  logic                                path_done;

  modport source (output valid, out_x, out_y, out_z, out_w, path_done, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, path_done, output ready);
endinterface

interface csps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [csps_pkg::CFG_IDX_W-1:0]    index;
  logic [csps_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/csps_basis.sv =====
// Hermite basis pipeline: squares and cubes the 16-bit fraction and forms the four weights.
// Depends on csps_pkg for the basis_t type.
module csps_basis (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [csps_pkg::T_W-1:0]  t_i,
  output csps_pkg::basis_t          basis_o
);
  import csps_pkg::*;

  localparam logic signed [H_W-1:0] H_ONE = 18'sd65536;

  logic [T_W-1:0]   t_q, t2_q, t3_q;
  logic [2*T_W-1:0] sq, cube;
  logic signed [H_W-1:0] e_t, e_t2, e_t3;
  basis_t basis_d, basis_q;

  assign sq   = t_q * t_q;
  assign cube = t2_q * t_q;

  assign e_t  = $signed({2'b00, t_q});
  assign e_t2 = $signed({2'b00, t2_q});
  assign e_t3 = $signed({2'b00, t3_q});

  always_comb begin
    basis_d.h00 = (e_t3 <<< 1) - e_t2 - (e_t2 <<< 1) + H_ONE;
    basis_d.h10 = e_t3 - (e_t2 <<< 1) + e_t;
    basis_d.h01 = e_t2 + (e_t2 <<< 1) - (e_t3 <<< 1);
    basis_d.h11 = e_t3 - e_t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else if (start_i) begin
      t_q <= t_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t2_q    <= sq[2*T_W-1:T_W];
    t3_q    <= cube[2*T_W-1:T_W];
    basis_q <= basis_d;
  end

  assign basis_o = basis_q;

endmodule

// ===== rtl/core/csps_lane.sv =====
// One component lane: holds four points, forms both tangents and the blended sum with
// a shared multiplier, then rounds and saturates (p1 at zero fraction); needs csps_pkg.
module csps_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  csps_pkg::lane_ctrl_t               ctrl_i,
  input  logic signed [csps_pkg::COORD_W-1:0] rdata_i,
  input  logic signed [csps_pkg::SCALE_W-1:0] scale_i,
  input  csps_pkg::basis_t                   basis_i,
  input  logic                               frac_zero_i,
  output logic signed [csps_pkg::COORD_W-1:0] result_o
);
  import csps_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;

  logic signed [COORD_W-1:0] p_q [4];
  logic signed [M_W-1:0]     m1_q, m2_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, rnd;
  lane_op_e                  op_q;
  logic signed [SCALE_W-1:0] mul_a;
  logic signed [M_W-1:0]     mul_b;
  logic signed [COORD_W:0]   diff_20, diff_31;
  logic signed [47:0]        shifted;
  logic signed [COORD_W-1:0] sat;

  assign diff_20 = $signed({p_q[2][COORD_W-1], p_q[2]}) - $signed({p_q[0][COORD_W-1], p_q[0]});
  assign diff_31 = $signed({p_q[3][COORD_W-1], p_q[3]}) - $signed({p_q[1][COORD_W-1], p_q[1]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      OP_M1: begin
        mul_a = scale_i;
        mul_b = M_W'(diff_20);
      end
      OP_M2: begin
        mul_a = scale_i;
        mul_b = M_W'(diff_31);
      end
      OP_H00P1: begin
        mul_a = SCALE_W'(basis_i.h00);
        mul_b = M_W'(p_q[1]);
      end
      OP_H01P2: begin
        mul_a = SCALE_W'(basis_i.h01);
        mul_b = M_W'(p_q[2]);
      end
      OP_H10M1: begin
        mul_a = SCALE_W'(basis_i.h10);
        mul_b = m1_q;
      end
      OP_H11M2: begin
        mul_a = SCALE_W'(basis_i.h11);
        mul_b = m2_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_IDLE;
    end else begin
      op_q <= ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (ctrl_i.ld_p[k]) begin
        p_q[k] <= rdata_i;
      end
    end
    prod_q <= prod_d;
    unique case (op_q)
      OP_M1:    m1_q  <= prod_q[M_W+15:16];
      OP_M2:    m2_q  <= prod_q[M_W+15:16];
      OP_H00P1: acc_q <= prod_q[ACC_W-1:0];
      OP_H01P2, OP_H10M1, OP_H11M2: acc_q <= acc_q + prod_q[ACC_W-1:0];
      default: ;
    endcase
  end

  assign rnd     = acc_q + ROUND_HALF;
  assign shifted = rnd[ACC_W-1:16];

  always_comb begin
    if (shifted[47:31] == {17{shifted[47]}}) begin
      sat = shifted[COORD_W-1:0];
    end else if (shifted[47]) begin
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  assign result_o = frac_zero_i ? p_q[1] : sat;

endmodule

// ===== rtl/core/cardinal_spline_path_stepper_core.sv =====
// Cardinal spline path stepper: request, result and configuration channels.
// A request item is a load (writes one table point, no result), a tick (advances the
// path position and gives one result item) or a restart (clears the position, no result).
// Other request codes are taken and ignored. Configuration writes set step size, tangent
// scale and segment count; they are taken in every cycle and must arrive while idle.
// After a load, restart or ignored item the next item is accepted at once.
// A tick goes from acceptance to its result entering the output register through four
// reads on the single read port of the point memory, one at a time, then six passes
// through the multiplier each component lane shares between tangents and blend weights.
// The four lanes run side by side, one per component; the output register captures all four.
// The output register holds a result until the receiver takes it; a new item is
// accepted meanwhile, and a following tick waits only if the register is still full.
// Reset clears the position and sets the registers to their defaults; point memory
// is not cleared and must be loaded before use.
// Depends on csps_pkg, csps_if, csps_basis and csps_lane.
module cardinal_spline_path_stepper_core #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csps_req_if.sink   req_i,
  csps_res_if.source res_o,
  csps_cfg_if.sink   cfg_i
);
  import csps_pkg::*;

  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int POS_W     = FRAC_BITS + SEG_W;
  localparam int SUM_W     = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
  localparam int LUT_DEPTH = 128;
  localparam int ROW_W     = NUM_LANES * COORD_W;

  localparam logic [3:0] CNT_RD_P1 = 4'd0;
  localparam logic [3:0] CNT_RD_P0 = 4'd1;
  localparam logic [3:0] CNT_RD_P2 = 4'd2;
  localparam logic [3:0] CNT_RD_P3 = 4'd3;
  localparam logic [3:0] CNT_LD_P3 = 4'd4;
  localparam logic [3:0] CNT_M2    = 4'd5;
  localparam logic [3:0] CNT_H00   = 4'd6;
  localparam logic [3:0] CNT_H01   = 4'd7;
  localparam logic [3:0] CNT_H10   = 4'd8;
  localparam logic [3:0] CNT_H11   = 4'd9;
  localparam logic [3:0] CNT_LAST  = 4'd11;

  typedef logic [IDX_W-1:0] slot_lut_t [LUT_DEPTH];

  function automatic slot_lut_t build_slot_lut();
    slot_lut_t lut;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      lut[i] = IDX_W'(i % MAX_POINTS);
    end
    return lut;
  endfunction

  localparam slot_lut_t SLOT_LUT = build_slot_lut();

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;

  state_e                    state_q;
  logic [3:0]                cnt_q;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [STEP_W-1:0]         step_q;
  logic signed [SCALE_W-1:0] scale_q;
  logic [SEG_W-1:0]          segs_q;
  logic [ROW_W-1:0]          point_mem [MAX_POINTS];
  logic [ROW_W-1:0]          rdata_q;
  logic [IDX_W-1:0]          rd_addr;
  logic [SEG_W:0]            seg_ext, rd_sel;
  logic [SEG_W-1:0]          seg;
  logic [FRAC_BITS-1:0]      frac;
  logic [T_W-1:0]            t;
  logic [POS_W-1:0]          lo, hi;
  logic [SUM_W-1:0]          sum, clamp_lo, clamp_hi;
  logic                      req_acc, cfg_acc, out_free;
  lane_ctrl_t                lane_ctrl;
  basis_t                    basis;
  logic signed [COORD_W-1:0] lane_res [NUM_LANES];
  logic signed [COORD_W-1:0] out_q [NUM_LANES];
  logic                      out_vld_q, done_q;

  assign req_acc  = req_i.valid && req_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free = !out_vld_q || res_o.ready;

  assign seg     = pos_q[POS_W-1 -: SEG_W];
  assign frac    = pos_q[FRAC_BITS-1:0];
  assign seg_ext = {1'b0, seg};

  generate
    if (FRAC_BITS >= T_W) begin : g_t_trunc
      assign t = frac[FRAC_BITS-1 -: T_W];
    end else begin : g_t_pad
      assign t = {frac, {(T_W-FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign lo       = POS_W'(1) << FRAC_BITS;
  assign hi       = {segs_q, {FRAC_BITS{1'b0}}};
  assign sum      = SUM_W'(pos_q) + SUM_W'(step_q);
  assign clamp_lo = (sum < SUM_W'(lo)) ? SUM_W'(lo) : sum;
  assign clamp_hi = (clamp_lo > SUM_W'(hi)) ? SUM_W'(hi) : clamp_lo;
  assign pos_d    = clamp_hi[POS_W-1:0];

  always_comb begin
    unique case (cnt_q)
      CNT_RD_P0: rd_sel = seg_ext - (SEG_W+1)'(1);
      CNT_RD_P2: rd_sel = seg_ext + (SEG_W+1)'(1);
      CNT_RD_P3: rd_sel = seg_ext + (SEG_W+1)'(2);
      default:   rd_sel = seg_ext;
    endcase
  end

  assign rd_addr = SLOT_LUT[rd_sel];

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.req_type == REQ_LOAD) begin
      point_mem[SLOT_LUT[{1'b0, req_i.point_index}]] <=
        {req_i.coord_w, req_i.coord_z, req_i.coord_y, req_i.coord_x};
    end
    rdata_q <= point_mem[rd_addr];
  end

  always_comb begin
    lane_ctrl.ld_p = '0;
    lane_ctrl.op   = OP_IDLE;
    if (state_q == ST_RUN) begin
      unique case (cnt_q)
        CNT_RD_P0: lane_ctrl.ld_p[1] = 1'b1;
        CNT_RD_P2: lane_ctrl.ld_p[0] = 1'b1;
        CNT_RD_P3: lane_ctrl.ld_p[2] = 1'b1;
        CNT_LD_P3: begin
          lane_ctrl.ld_p[3] = 1'b1;
          lane_ctrl.op      = OP_M1;
        end
        CNT_M2:  lane_ctrl.op = OP_M2;
        CNT_H00: lane_ctrl.op = OP_H00P1;
        CNT_H01: lane_ctrl.op = OP_H01P2;
        CNT_H10: lane_ctrl.op = OP_H10M1;
        CNT_H11: lane_ctrl.op = OP_H11M2;
        default: lane_ctrl.op = OP_IDLE;
      endcase
    end
  end

  csps_basis u_basis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_RUN && cnt_q == CNT_RD_P1),
    .t_i     (t),
    .basis_o (basis)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    csps_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl),
      .rdata_i     ($signed(rdata_q[g*COORD_W +: COORD_W])),
      .scale_i     (scale_q),
      .basis_i     (basis),
      .frac_zero_i (frac == '0),
      .result_o    (lane_res[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      scale_q <= SCALE_RESET;
      segs_q  <= SEGS_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        CFG_STEP_SIZE:     step_q  <= STEP_W'(cfg_i.data);
        CFG_TANGENT_SCALE: scale_q <= $signed(cfg_i.data[SCALE_W-1:0]);
        CFG_SEGMENT_COUNT: segs_q  <= cfg_i.data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
      done_q    <= 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
        out_q[k] <= '0;
      end
    end else begin
      if (out_vld_q && res_o.ready && state_q != ST_DONE) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (req_acc) begin
            unique case (req_i.req_type)
              REQ_TICK: begin
                pos_q   <= pos_d;
                state_q <= ST_RUN;
              end
              REQ_RESTART: pos_q <= '0;
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            for (int k = 0; k < NUM_LANES; k++) begin
              out_q[k] <= lane_res[k];
            end
            done_q    <= (pos_q == hi);
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.out_x     = out_q[0];
  assign res_o.out_y     = out_q[1];
  assign res_o.out_z     = out_q[2];
  assign res_o.out_w     = out_q[3];
  assign res_o.path_done = done_q;

endmodule

// ===== rtl/core/csps_checker.sv =====
// Port-level checks of the spline path stepper, bound to the top level.
// Depends on csps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csps_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid,
  input logic         in_ready,
  input logic [1:0]   in_req,
  input logic         out_valid,
  input logic         out_ready,
  input logic [127:0] out_data,
  input logic         out_done
);
  import csps_pkg::*;

  `CSPS_ASSERT_NEXT(a_tick_blocks, in_valid && in_ready && in_req == REQ_TICK, !in_ready, "tick item did not block the request channel")
  `CSPS_ASSERT_NEXT(a_other_free, in_valid && in_ready && in_req != REQ_TICK, in_ready, "non-tick item blocked the request channel")
  `CSPS_ASSERT_NOW(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(out_data) && $stable(out_done)), "stalled result changed")

endmodule

bind cardinal_spline_path_stepper_core csps_checker u_csps_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .in_req    (req_i.req_type),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_data  ({res_o.out_w, res_o.out_z, res_o.out_y, res_o.out_x}),
  .out_done  (res_o.path_done)
);

// ===== verif/tb_cardinal_spline_path_stepper_core.sv =====
// Self-checking testbench of cardinal_spline_path_stepper_core: loads, ticks, restarts and
// register writes, with each tick result checked against a built-in spline predictor.
// Depends on csps_pkg, the csps interfaces and the core.
module tb_cardinal_spline_path_stepper_core;
  timeunit 1ns;
  timeprecision 1ps;
  import csps_pkg::*;

  localparam int NPTS = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [5:0]       idx;
    logic [3:0][31:0] crd;
  } path_req_t;

  typedef struct packed {
    logic [3:0][31:0] crd;
    logic             done;
  } path_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  csps_req_if req();
  csps_res_if res();
  csps_cfg_if cfg();

  cardinal_spline_path_stepper_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res),
    .cfg_i (cfg)
  );

  always #5 clk_i = ~clk_i;

  logic [3:0][31:0]    ctl_points[NPTS];
  logic [21:0]         path_pos;
  logic [21:0]         step_reg;
  logic signed [23:0]  scale_reg;
  logic [5:0]          segs_reg;
  path_point_t         expected_points[$];
  int                  errors = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_req = 0;
  int                  hold_left = 0;
  int                  cycles = 0;

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void predict_path(path_req_t it);
    longint pos, lo, hi, t, t2, t3, h00, h10, h01, h11;
    longint p0, p1, p2, p3, m1, m2, acc, sc;
    int seg, a, b, d, e;
    path_point_t pt;
    case (it.kind)
      REQ_LOAD: ctl_points[it.idx] = it.crd;
      REQ_RESTART: path_pos = '0;
      REQ_TICK: begin
        lo = 64'd1 << 16;
        hi = longint'(segs_reg) << 16;
        pos = longint'(path_pos) + longint'(step_reg);
        if (pos < lo) pos = lo;
        if (pos > hi) pos = hi;
        path_pos = pos[21:0];
        seg = int'(pos >> 16);
        t = pos & 64'hffff;
        b = seg % NPTS;
        if (t == 0) begin
          for (int c = 0; c < 4; c++) pt.crd[c] = ctl_points[b][c];
        end else begin
          a = (seg + NPTS - 1) % NPTS;
          d = (seg + 1) % NPTS;
          e = (seg + 2) % NPTS;
          t2 = (t * t) >> 16;
          t3 = (t2 * t) >> 16;
          h00 = 2 * t3 - 3 * t2 + 65536;
          h10 = t3 - 2 * t2 + t;
          h01 = 3 * t2 - 2 * t3;
          h11 = t3 - t2;
          sc = scale_reg;
          for (int c = 0; c < 4; c++) begin
            p0 = $signed(ctl_points[a][c]);
            p1 = $signed(ctl_points[b][c]);
            p2 = $signed(ctl_points[d][c]);
            p3 = $signed(ctl_points[e][c]);
            m1 = (sc * (p2 - p0)) >>> 16;
            m2 = (sc * (p3 - p1)) >>> 16;
            acc = h00 * p1 + h10 * m1 + h01 * p2 + h11 * m2;
            pt.crd[c] = sat32((acc + 32768) >>> 16);
          end
        end
        pt.done = (pos == hi);
        expected_points = {expected_points, pt};
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(path_req_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.req_type    <= it.kind;
    req.point_index <= it.idx;
    req.coord_x     <= it.crd[0];
    req.coord_y     <= it.crd[1];
    req.coord_z     <= it.crd[2];
    req.coord_w     <= it.crd[3];
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_path(it);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      CFG_STEP_SIZE:     step_reg = val[21:0];
      CFG_TANGENT_SCALE: scale_reg = val;
      CFG_SEGMENT_COUNT: segs_reg = val[5:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [21:0] stp, logic [23:0] scl, logic [5:0] sgs);
    wait_idle();
    write_reg(CFG_STEP_SIZE, {2'b00, stp});
    write_reg(CFG_TANGENT_SCALE, scl);
    write_reg(CFG_SEGMENT_COUNT, {18'd0, sgs});
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic path_req_t make_req(logic [1:0] kind, logic [5:0] idx);
    path_req_t it;
    it.kind = kind;
    it.idx  = idx;
    for (int c = 0; c < 4; c++) it.crd[c] = rand_coord();
    return it;
  endfunction

  task automatic test_table_fill();
    for (int i = 0; i < NPTS; i++) send_req(make_req(REQ_LOAD, 6'(i)));
  endtask

  task automatic test_directed();
    path_req_t it;
    it = make_req(REQ_LOAD, 6'd2);
    it.crd = {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_req(it);
    it.idx = 6'd3;
    it.crd = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    send_req(it);
    send_req(make_req(REQ_TICK, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    send_req(make_req(2'd3, 6'd63));
    send_req(make_req(REQ_RESTART, 6'd0));
    configure(22'd0, 24'h7fffff, 6'd4);
    send_req(make_req(REQ_TICK, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    configure(22'h3fffff, 24'h800000, 6'd62);
    send_req(make_req(REQ_RESTART, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    configure(22'd32768, 24'h800000, 6'd62);
    send_req(make_req(REQ_RESTART, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    send_req(make_req(REQ_TICK, 6'd0));
    configure(22'd40000, 24'h7fffff, 6'd4);
    for (int i = 0; i < 8; i++) send_req(make_req(REQ_TICK, 6'd0));
  endtask

  task automatic test_random_phase(int n_items);
    logic [21:0] stp;
    int r;
    case ($urandom_range(3))
      0: stp = 22'($urandom_range(4000));
      1: stp = 22'($urandom_range(70000));
      2: stp = 22'($urandom_range(400000));
      default: stp = 22'h3fffff;
    endcase
    configure(stp, 24'($urandom()), 6'($urandom_range(4, 62)));
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 70) send_req(make_req(REQ_TICK, 6'($urandom())));
      else if (r < 76) send_req(make_req(REQ_RESTART, 6'($urandom())));
      else if (r < 95) send_req(make_req(REQ_LOAD, 6'($urandom())));
      else send_req(make_req(2'd3, 6'($urandom())));
    end
  endtask

  task automatic test_backpressure();
    configure(22'd9000, 24'd32768, 6'd62);
    hold_req = 300;
    for (int i = 0; i < 40; i++) send_req(make_req(REQ_TICK, 6'd0));
    wait_idle();
    for (int i = 0; i < 10; i++) send_req(make_req(REQ_TICK, 6'd0));
  endtask

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    path_point_t exp_pt;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_points.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (res.out_x !== exp_pt.crd[0]) begin
          $error("out_x: expected %0d, got %0d", $signed(exp_pt.crd[0]), res.out_x);
          errors++;
        end
        if (res.out_y !== exp_pt.crd[1]) begin
          $error("out_y: expected %0d, got %0d", $signed(exp_pt.crd[1]), res.out_y);
          errors++;
        end
        if (res.out_z !== exp_pt.crd[2]) begin
          $error("out_z: expected %0d, got %0d", $signed(exp_pt.crd[2]), res.out_z);
          errors++;
        end
        if (res.out_w !== exp_pt.crd[3]) begin
          $error("out_w: expected %0d, got %0d", $signed(exp_pt.crd[3]), res.out_w);
          errors++;
        end
        if (res.path_done !== exp_pt.done) begin
          $error("path_done: expected %0d, got %0d", exp_pt.done, res.path_done);
          errors++;
        end
      end
    end
    res.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_LOAD;
    req.point_index = '0;
    req.coord_x = '0;
    req.coord_y = '0;
    req.coord_z = '0;
    req.coord_w = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_STEP_SIZE;
    cfg.data = '0;
    path_pos = '0;
    step_reg = STEP_RESET;
    scale_reg = SCALE_RESET;
    segs_reg = SEGS_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    for (int i = 0; i < 6; i++) send_req(make_req(REQ_TICK, 6'd0));
    test_directed();
    send_idle_pct = 7;
    recv_idle_pct = 67;
    test_random_phase(300);
    test_random_phase(300);
    send_idle_pct = 67;
    recv_idle_pct = 7;
    test_random_phase(300);
    test_random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(300);
    test_random_phase(300);
    test_backpressure();
    wait_idle();
    if (errors == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
